>>> rtl/tcw_pkg.sv
// Shared types, constants and helpers for the text console writer.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 24;

  localparam int CELL_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int CURSOR_W = 11;
  localparam int RADDR_W  = 11;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'hFF;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic                 cmd;
    logic [CHAR_W-1:0]    char_byte;
    logic [RADDR_W-1:0]   read_address;
  } item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0]  cursor;
    logic [CELL_W-1:0]    word;
  } res_t;

  // top -> sequencer
  typedef struct packed {
    logic accept;
    logic res_taken;
  } ctl_t;

  // sequencer -> top
  typedef struct packed {
    logic idle;
    logic res_pend;
  } sts_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] attr,
                                                  input logic [CHAR_W-1:0] ch);
    return {attr, ch};
  endfunction

endpackage

>>> rtl/text_console_writer.sv
// Top level of the text console writer: handshakes, attribute register, output stage.
// Puts and out-of-range reads pass through S_EXEC to S_DONE; cell reads add S_READ for the registered read.
// One item at a time: a new item is taken only while idle or when the previous result is taken.
// A newline on the last row or a character in the last cell starts a scroll sweep through
// the single write port. Reset (rst, synchronous) starts a clearing pass over every cell;
// no item is taken until it ends. Attribute writes are taken at any time.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_byte,
  input  logic [tcw_pkg::RADDR_W-1:0]  read_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcw_pkg::CURSOR_W-1:0] cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]   cell_word,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tcw_pkg::CHAR_W-1:0]   cfg_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  tcw_pkg::ctl_t              ctl;
  tcw_pkg::sts_t              sts;
  tcw_pkg::res_t              res;
  tcw_pkg::item_t             item;
  logic [tcw_pkg::CHAR_W-1:0] attr;
  logic                       out_free;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  assign item.cmd          = cmd;
  assign item.char_byte    = char_byte;
  assign item.read_address = read_address;

  assign out_free      = !out_valid || !out_stall;
  assign ctl.res_taken = sts.res_pend && out_free;
  assign in_stall      = !(sts.idle || ctl.res_taken);
  assign ctl.accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_taken) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_taken) begin
      cursor_position <= res.cursor;
      cell_word       <= res.word;
    end
  end

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .item      (item),
    .attr      (attr),
    .sts       (sts),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1920,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tcw_seq.sv
// Command sequencer: cursor tracking, store clear, scroll sweep, cell reads.
module tcw_seq #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int CELLS   = COLUMNS * ROWS,
  parameter int ADDR_W  = $clog2(CELLS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tcw_pkg::ctl_t              ctl,
  input  tcw_pkg::item_t             item,
  input  logic [tcw_pkg::CHAR_W-1:0] attr,
  output tcw_pkg::sts_t              sts,
  output tcw_pkg::res_t              res,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
  output logic                       ram_re,
  output logic [ADDR_W-1:0]          ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rdata
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW0  = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W:0]   SRC_AHEAD  = (ADDR_W + 1)'(COLUMNS + 1);
  localparam logic [ADDR_W:0]   CELLS_EXT  = (ADDR_W + 1)'(CELLS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_READ   = 6'b001000,
    S_SCROLL = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                       state, state_next;
  logic [ADDR_W-1:0]            cnt, cnt_next;
  logic [ADDR_W-1:0]            pos, pos_next;
  logic [COL_W-1:0]             col, col_next;
  logic [ROW_W-1:0]             row, row_next;
  logic [tcw_pkg::CELL_W-1:0]   word, word_next;
  tcw_pkg::item_t               cur;
  logic [ADDR_W:0]              src;
  logic [tcw_pkg::CELL_W-1:0]   blank;
  logic                         addr_ok;

  assign blank   = tcw_pkg::make_cell(attr, tcw_pkg::CHAR_BLANK);
  assign src     = (ADDR_W + 1)'(cnt) + SRC_AHEAD;
  assign addr_ok = 32'(cur.read_address) < 32'(CELLS);

  assign sts.idle     = (state == S_IDLE);
  assign sts.res_pend = (state == S_DONE);
  assign res.cursor   = tcw_pkg::CURSOR_W'(pos);
  assign res.word     = word;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pos_next   = pos;
    col_next   = col;
    row_next   = row;
    word_next  = word;
    ram_we     = 1'b0;
    ram_waddr  = cnt;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = ROW_STEP;

    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        cnt_next  = cnt + 1'b1;
        if (cnt == LAST_CELL) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (ctl.accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        word_next  = '0;
        state_next = S_DONE;
        if (cur.cmd == tcw_pkg::CMD_READ) begin
          if (addr_ok) begin
            ram_re     = 1'b1;
            ram_raddr  = ADDR_W'(cur.read_address);
            state_next = S_READ;
          end
        end else begin
          priority if (cur.char_byte == tcw_pkg::CHAR_NUL ||
                       cur.char_byte == tcw_pkg::CHAR_DEL) begin
            // ignored byte
          end else if (cur.char_byte == tcw_pkg::CHAR_BS) begin
            if (pos != '0) begin
              pos_next = pos - 1'b1;
              if (col == '0) begin
                // wrap to previous row, no erase
                col_next = LAST_COL;
                row_next = row - 1'b1;
              end else begin
                col_next  = col - 1'b1;
                ram_we    = 1'b1;
                ram_waddr = pos - 1'b1;
                ram_wdata = blank;
              end
            end
          end else if (cur.char_byte == tcw_pkg::CHAR_LF ||
                       cur.char_byte == tcw_pkg::CHAR_CR) begin
            if (row == LAST_ROW) begin
              ram_re     = 1'b1;
              ram_raddr  = ROW_STEP;
              cnt_next   = '0;
              pos_next   = LAST_ROW0;
              col_next   = '0;
              state_next = S_SCROLL;
            end else begin
              pos_next = pos - ADDR_W'(col) + ROW_STEP;
              col_next = '0;
              row_next = row + 1'b1;
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = pos;
            ram_wdata = tcw_pkg::make_cell(attr, cur.char_byte);
            if (pos == LAST_CELL) begin
              // prime the first copy read; the last cell lands before it is read
              ram_re     = 1'b1;
              ram_raddr  = ROW_STEP;
              cnt_next   = '0;
              pos_next   = LAST_ROW0;
              col_next   = '0;
              state_next = S_SCROLL;
            end else begin
              pos_next = pos + 1'b1;
              if (col == LAST_COL) begin
                col_next = '0;
                row_next = row + 1'b1;
              end else begin
                col_next = col + 1'b1;
              end
            end
          end
        end
      end

      S_READ: begin
        word_next  = ram_rdata;
        state_next = S_DONE;
      end

      S_SCROLL: begin
        // write cnt from the read issued last cycle, read one row ahead
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = (cnt < COPY_END) ? ram_rdata : blank;
        ram_re    = (src < CELLS_EXT);
        ram_raddr = src[ADDR_W-1:0];
        cnt_next  = cnt + 1'b1;
        if (cnt == LAST_CELL) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (ctl.res_taken) begin
          state_next = ctl.accept ? S_EXEC : S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      pos   <= '0;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pos   <= pos_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
    if (ctl.accept) begin
      cur <= item;
    end
  end

endmodule

>>> rtl/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tcw_pkg::CURSOR_W-1:0] cursor_position,
  input logic [tcw_pkg::CELL_W-1:0]   cell_word
);

  localparam int CELLS = COLUMNS * ROWS;

  // one item at a time: the cycle after an accept never takes another
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted on consecutive cycles");

  // clearing pass blocks input right after reset
  a_clear_stall: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("input open during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cursor_position) && $stable(cell_word))
    else $error("stalled result changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(cursor_position) < CELLS) || (CELLS > 2048))
    else $error("cursor outside the screen");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);

>>> sim/text_console_checker.sv
`timescale 1ns / 1ps
// Checker for the text console writer: tracks cursor and screen, compares every result.
module text_console_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_byte,
  input  logic [tcw_pkg::RADDR_W-1:0]  read_address,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [tcw_pkg::CURSOR_W-1:0] cursor_position,
  input  logic [tcw_pkg::CELL_W-1:0]   cell_word,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [tcw_pkg::CHAR_W-1:0]   cfg_data,
  output int                           error_count,
  output int                           pending_count,
  output int                           checked_count,
  output int                           scroll_count
);

  localparam int COLS  = tcw_pkg::COLUMNS_DEF;
  localparam int CELLS = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF;

  logic [tcw_pkg::CHAR_W-1:0]   attr;
  logic [tcw_pkg::CURSOR_W-1:0] cursor;
  logic [tcw_pkg::CELL_W-1:0]   screen [CELLS];
  tcw_pkg::res_t                expected_q [$];
  int                           errs = 0;
  int                           checked = 0;
  int                           scrolls = 0;

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {attr, tcw_pkg::CHAR_BLANK};
    cursor = tcw_pkg::CURSOR_W'(CELLS - COLS);
    scrolls++;
  endfunction

  // Updates cursor and screen for one item and returns what the block should report.
  function automatic tcw_pkg::res_t apply_item(input logic c,
                                               input logic [tcw_pkg::CHAR_W-1:0] ch,
                                               input logic [tcw_pkg::RADDR_W-1:0] addr);
    tcw_pkg::res_t r;
    r.word = '0;
    if (c == tcw_pkg::CMD_READ) begin
      if (addr < CELLS) r.word = screen[addr];
    end else if (ch != tcw_pkg::CHAR_NUL && ch != tcw_pkg::CHAR_DEL) begin
      if (ch == tcw_pkg::CHAR_BS) begin
        // at column zero the cursor only wraps back, nothing is blanked
        if (cursor % COLS != 0) begin
          cursor = cursor - 1'b1;
          screen[cursor] = {attr, tcw_pkg::CHAR_BLANK};
        end else if (cursor != 0) begin
          cursor = cursor - 1'b1;
        end
      end else if (ch == tcw_pkg::CHAR_LF || ch == tcw_pkg::CHAR_CR) begin
        cursor = tcw_pkg::CURSOR_W'((cursor / COLS + 1) * COLS);
        if (cursor >= CELLS) scroll_screen();
      end else begin
        screen[cursor] = {attr, ch};
        cursor = cursor + 1'b1;
        if (cursor >= CELLS) scroll_screen();
      end
    end
    r.cursor = cursor;
    return r;
  endfunction

  always @(posedge clk) begin
    tcw_pkg::res_t exp_r;
    if (rst) begin
      attr   = tcw_pkg::ATTR_RESET;
      cursor = '0;
      foreach (screen[i]) screen[i] = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) attr = cfg_data;
      if (in_valid && !in_stall)
        expected_q.push_back(apply_item(cmd, char_byte, read_address));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: cursor_position %0d, cell_word 0x%04h",
                   $time, cursor_position, cell_word);
        end else begin
          exp_r = expected_q.pop_front();
          checked++;
          if (cursor_position !== exp_r.cursor) begin
            errs++;
            $display("%0t: cursor_position mismatch: expected %0d, got %0d",
                     $time, exp_r.cursor, cursor_position);
          end
          if (cell_word !== exp_r.word) begin
            errs++;
            $display("%0t: cell_word mismatch: expected 0x%04h, got 0x%04h",
                     $time, exp_r.word, cell_word);
          end
        end
      end
    end
    error_count   <= errs;
    pending_count <= expected_q.size();
    checked_count <= checked;
    scroll_count  <= scrolls;
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the text console writer: clock, reset, stimulus and verdict.
module testbench;

  localparam int CELLS = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         cmd = tcw_pkg::CMD_PUT;
  logic [tcw_pkg::CHAR_W-1:0]   char_byte = '0;
  logic [tcw_pkg::RADDR_W-1:0]  read_address = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [tcw_pkg::CURSOR_W-1:0] cursor_position;
  logic [tcw_pkg::CELL_W-1:0]   cell_word;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [tcw_pkg::CHAR_W-1:0]   cfg_data = '0;

  int error_count, pending_count, checked_count, scroll_count;
  int idle_pct    = 36;
  int stall_pct   = 36;
  int items_sent  = 0;
  int attr_writes = 0;

  text_console_writer u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .char_byte       (char_byte),
    .read_address    (read_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_position (cursor_position),
    .cell_word       (cell_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  text_console_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .char_byte       (char_byte),
    .read_address    (read_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_position (cursor_position),
    .cell_word       (cell_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .pending_count   (pending_count),
    .checked_count   (checked_count),
    .scroll_count    (scroll_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) out_stall <= !rst && ($urandom_range(99) < stall_pct);

  task automatic send_item(input logic c, input logic [tcw_pkg::CHAR_W-1:0] ch,
                           input logic [tcw_pkg::RADDR_W-1:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    char_byte    <= ch;
    read_address <= addr;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic put_char(input logic [tcw_pkg::CHAR_W-1:0] ch);
    send_item(tcw_pkg::CMD_PUT, ch, tcw_pkg::RADDR_W'($urandom_range(2047)));
  endtask

  task automatic read_cell(input int addr);
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_W'($urandom_range(255)),
              tcw_pkg::RADDR_W'(addr));
  endtask

  // let every outstanding result come back before touching the attribute
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_attr(input logic [tcw_pkg::CHAR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    attr_writes++;
  endtask

  // one random burst: a line of text, a group of reads, backspaces or noise
  task automatic send_burst();
    int kind, len, pick;
    kind = $urandom_range(99);
    if (kind < 55) begin
      len = $urandom_range(100, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 8) put_char(tcw_pkg::CHAR_BS);
        else if ($urandom_range(99) < 85)
          put_char(tcw_pkg::CHAR_W'($urandom_range(8'h7E, 8'h21)));
        else put_char(tcw_pkg::CHAR_W'($urandom_range(255)));
      end
      if ($urandom_range(99) < 85)
        put_char($urandom_range(1) ? tcw_pkg::CHAR_LF : tcw_pkg::CHAR_CR);
    end else if (kind < 75) begin
      len = $urandom_range(6, 1);
      repeat (len) begin
        pick = $urandom_range(9);
        if (pick < 5) read_cell($urandom_range(CELLS - 1));
        else if (pick < 8)
          read_cell($urandom_range(CELLS - 1, CELLS - 2 * tcw_pkg::COLUMNS_DEF));
        else read_cell($urandom_range(2047));
      end
    end else if (kind < 88) begin
      if ($urandom_range(1)) put_char(tcw_pkg::CHAR_LF);
      repeat ($urandom_range(3, 1)) put_char(tcw_pkg::CHAR_BS);
    end else begin
      repeat ($urandom_range(5, 1))
        send_item(1'($urandom_range(1)), tcw_pkg::CHAR_W'($urandom_range(255)),
                  tcw_pkg::RADDR_W'($urandom_range(2047)));
    end
  endtask

  initial begin
    int target;
    logic [tcw_pkg::CHAR_W-1:0] phase_attr [5];
    phase_attr = '{8'hFF, 8'h00, tcw_pkg::CHAR_W'($urandom), 8'h5A,
                   tcw_pkg::CHAR_W'($urandom)};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed items under the reset attribute
    read_cell(0);
    read_cell(CELLS - 1);
    read_cell(CELLS);
    read_cell(2047);
    put_char(tcw_pkg::CHAR_NUL);
    put_char(tcw_pkg::CHAR_DEL);
    put_char(tcw_pkg::CHAR_BS);
    put_char(8'h41);
    put_char(8'h80);
    put_char(8'hFE);
    put_char(8'h01);
    put_char(tcw_pkg::CHAR_BS);
    read_cell(3);
    read_cell(0);
    put_char(tcw_pkg::CHAR_LF);
    put_char(tcw_pkg::CHAR_BS);
    put_char(tcw_pkg::CHAR_CR);
    put_char(8'h7F);
    put_char(tcw_pkg::CHAR_LF);
    read_cell(tcw_pkg::COLUMNS_DEF);
    read_cell(2);
    drain();

    foreach (phase_attr[p]) begin
      write_attr(phase_attr[p]);
      // the middle phase runs with both sides at full speed
      idle_pct  = (p == 2) ? 0 : 36;
      stall_pct = (p == 2) ? 0 : 36;
      target = items_sent + 160;
      while (items_sent < target) send_burst();
      drain();
    end

    $display("Run covered %0d items under %0d attribute values, %0d results checked.",
             items_sent, attr_writes + 1, checked_count);
    $display("The screen scrolled %0d times along the way.", scroll_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
